// ===== src/tsc_pkg.sv =====
`default_nettype none
package tsc_pkg;

	localparam int unsigned PID_W = 13;
	localparam int unsigned CC_W  = 4;
	localparam int unsigned RUN_W = 16;

	localparam logic [RUN_W-1:0] RUN_MAX          = 16'hFFFF;
	localparam logic [RUN_W-1:0] THRESHOLD_RESET  = 16'd10;
	localparam logic [CC_W-1:0]  CC_STEP          = 4'd1;

	typedef struct packed {
		logic [PID_W-1:0] stream_pid;
		logic [CC_W-1:0]  counter_value;
	} tsc_in_t;

	typedef struct packed {
		logic             new_stream;
		logic             table_full;
		logic             cc_mismatch;
		logic [CC_W-1:0]  expected_value;
		logic [RUN_W-1:0] error_run;
		logic             threshold_hit;
	} tsc_out_t;

	// head of the queue between front and back
	typedef struct packed {
		logic    valid;
		tsc_in_t item;
	} tsc_head_t;

	// one PID table entry
	typedef struct packed {
		logic [PID_W-1:0] pid;
		logic [CC_W-1:0]  last_cc;
		logic [RUN_W-1:0] run;
	} tsc_entry_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_RESOLVE
	} tsc_back_state_t;

endpackage
`default_nettype wire

// ===== src/tsc_front.sv =====
`default_nettype none
module tsc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire tsc_pkg::tsc_in_t in_data,
	input  wire logic            pop,
	output tsc_pkg::tsc_head_t   head
);
	import tsc_pkg::*;

	// two-deep header queue
	tsc_in_t    buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign head.valid = (count_q != 2'd0);
	assign head.item  = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= in_data;
	end

endmodule
`default_nettype wire

// ===== src/tsc_back.sv =====
`default_nettype none
module tsc_back #(
	parameter int unsigned PID_SLOTS = 128
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire tsc_pkg::tsc_head_t         head,
	output logic                            pop,
	input  wire logic [tsc_pkg::RUN_W-1:0]  threshold,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output tsc_pkg::tsc_out_t               out_data
);
	import tsc_pkg::*;

	localparam int unsigned IDX_W = (PID_SLOTS > 1) ? $clog2(PID_SLOTS) : 1;
	localparam int unsigned CNT_W = $clog2(PID_SLOTS + 1);
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(PID_SLOTS);

	tsc_entry_t      pid_mem [PID_SLOTS];
	tsc_entry_t      rd_data_q;

	tsc_back_state_t state_q, state_d;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic [IDX_W-1:0] cmp_idx_q;
	logic             cmp_valid_q;
	tsc_in_t          item_s1;
	logic [IDX_W-1:0] hit_idx_q;
	tsc_entry_t       hit_entry_q;
	logic             miss_q;
	logic             out_valid_q;
	tsc_out_t         out_q;

	logic             rd_en;
	logic             hit;
	logic             miss;
	logic             emit;
	logic             full;
	logic             last_cmp;

	logic [CC_W-1:0]  expected;
	logic             mism;
	logic             run_sat;
	logic [RUN_W-1:0] run_new;
	tsc_out_t         result;
	tsc_entry_t       wr_entry;

	assign full     = (used_q == SLOTS_C);
	assign last_cmp = ((CNT_W'(cmp_idx_q) + CNT_W'(1)) == used_q);
	assign hit      = (state_q == BK_SCAN) && cmp_valid_q
	                  && (rd_data_q.pid == item_s1.stream_pid);
	assign miss     = (state_q == BK_SCAN) && cmp_valid_q && !hit && last_cmp;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		rd_en   = 1'b0;
		emit    = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (head.valid) begin
					pop     = 1'b1;
					state_d = (used_q == '0) ? BK_RESOLVE : BK_SCAN;
				end
			end
			BK_SCAN: begin
				rd_en = (scan_idx_q < used_q);
				if (hit || miss)
					state_d = BK_RESOLVE;
			end
			BK_RESOLVE: begin
				if (!out_valid_q || out_ready) begin
					emit    = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// update of a known PID
	assign expected = hit_entry_q.last_cc + CC_STEP;
	assign mism     = (expected != item_s1.counter_value);
	assign run_sat  = (hit_entry_q.run == RUN_MAX);
	always_comb begin
		if (!mism)
			run_new = '0;
		else if (run_sat)
			run_new = hit_entry_q.run;
		else
			run_new = hit_entry_q.run + RUN_W'(1);
	end

	always_comb begin
		result = '0;
		if (miss_q) begin
			result.new_stream = 1'b1;
			result.table_full = full;
		end else begin
			result.cc_mismatch    = mism;
			result.expected_value = expected;
			result.error_run      = run_new;
			result.threshold_hit  = mism && !run_sat && (run_new == threshold);
		end
	end

	always_comb begin
		wr_entry.pid     = item_s1.stream_pid;
		wr_entry.last_cc = item_s1.counter_value;
		wr_entry.run     = miss_q ? '0 : run_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			used_q      <= '0;
			scan_idx_q  <= '0;
			cmp_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cmp_valid_q <= rd_en;
			if (pop)
				scan_idx_q <= '0;
			else if (rd_en)
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			if (emit && miss_q && !full)
				used_q <= used_q + CNT_W'(1);
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= pid_mem[scan_idx_q[IDX_W-1:0]];
		if (emit) begin
			if (!miss_q)
				pid_mem[hit_idx_q] <= wr_entry;
			else if (!full)
				pid_mem[used_q[IDX_W-1:0]] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			cmp_idx_q <= scan_idx_q[IDX_W-1:0];
		if (pop) begin
			item_s1 <= head.item;
			miss_q  <= (used_q == '0);
		end else if (hit || miss) begin
			miss_q <= miss;
		end
		if (hit) begin
			hit_idx_q   <= cmp_idx_q;
			hit_entry_q <= rd_data_q;
		end
		if (emit)
			out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// ===== src/ts_continuity_counter_checker_unit.sv =====
// Scan: an item whose PID matches entry k is resolved once entries 0..k have been read;
//   a new PID is resolved after all N stored entries are read (none with an empty table).
// Throughput: the back handles one item at a time and scans the table on the single read port
//   of the PID memory, one entry per cycle; a two-deep queue keeps taking beats meanwhile until full.
// Reset (arst_n low, async): empties the queue and the table count, drops the output beat,
//   loads the error threshold with 10; table contents are not cleared and need no sweep.
`default_nettype none
module ts_continuity_counter_checker_unit #(
	parameter int unsigned PID_SLOTS = 128
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// input beats: one TS header each
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire tsc_pkg::tsc_in_t          in_data,
	// result beats: one per header
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output tsc_pkg::tsc_out_t              out_data,
	// error threshold register
	input  wire logic                      cfg_we,
	input  wire logic [tsc_pkg::RUN_W-1:0] cfg_wdata
);
	import tsc_pkg::*;

	logic [RUN_W-1:0] threshold_q;
	tsc_head_t        head;
	logic             pop;

	// the user sees to it that the threshold only changes while the block is idle; the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			threshold_q <= THRESHOLD_RESET;
		else if (cfg_we)
			threshold_q <= cfg_wdata;
	end

	// front: takes header beats into a short queue
	tsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.pop      (pop),
		.head     (head)
	);

	// back: scans the PID table, updates or adds the entry, holds the result beat
	tsc_back #(
		.PID_SLOTS (PID_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.threshold (threshold_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== src/tsc_checker.sv =====
`default_nettype none
module tsc_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire tsc_pkg::tsc_in_t          in_data,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire tsc_pkg::tsc_out_t         out_data
);
	import tsc_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input beat dropped or changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat dropped or changed while stalled");

	a_full_is_new: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.table_full |-> out_data.new_stream)
		else $error("table_full without new_stream");

	a_new_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.new_stream |-> !out_data.cc_mismatch
			&& !out_data.threshold_hit && (out_data.error_run == '0)
			&& (out_data.expected_value == '0))
		else $error("new stream carries compare results");

	a_thr_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.threshold_hit |-> out_data.cc_mismatch
			&& (out_data.error_run != '0) && !out_data.new_stream)
		else $error("threshold hit without a counted mismatch");

endmodule

bind ts_continuity_counter_checker_unit tsc_checker u_tsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

// ===== test/tb_ts_continuity_counter_checker_unit.sv =====
module tb_ts_continuity_counter_checker_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import tsc_pkg::*;

	// table depth used for the instance and for the local mirror of the PID table
	localparam int unsigned SLOTS          = 128;
	localparam int unsigned SLOT_W         = $clog2(SLOTS);
	// worst gap without any beat: a full table scan plus a long receiver stall
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	// quiet time after the last result, more than one full-table latency
	localparam int unsigned TAIL_CYCLES    = 300;
	localparam int unsigned REPORT_MAX     = 10;
	localparam int unsigned PHASE_BEATS    = 380;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	tsc_in_t           in_data;
	logic              out_valid;
	logic              out_ready;
	tsc_out_t          out_data;
	logic              cfg_we;
	logic [RUN_W-1:0]  cfg_wdata;

	// mirror of the PID table, filled in order of first arrival
	logic [PID_W-1:0]  pid_tab [SLOTS];
	logic [CC_W-1:0]   cc_tab  [SLOTS];
	logic [RUN_W-1:0]  run_tab [SLOTS];
	int unsigned       streams_stored;
	logic [RUN_W-1:0]  threshold;

	// results still owed by the block, oldest first
	tsc_out_t          expected_results [$];

	// idling knobs, percent of cycles
	int unsigned       send_idle_pct;
	int unsigned       recv_stall_pct;

	int unsigned       mismatches;
	int unsigned       idle_cycles;
	int unsigned       beats_in;
	int unsigned       beats_out;
	int unsigned       n_new;
	int unsigned       n_full;
	int unsigned       n_cc_err;
	int unsigned       n_hits;
	int                last_idx;

	ts_continuity_counter_checker_unit #(
		.PID_SLOTS (SLOTS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// slot holding this PID, -1 when unknown
	function automatic int find_stream(logic [PID_W-1:0] pid);
		for (int i = 0; i < int'(streams_stored); i++)
			if (pid_tab[SLOT_W'(i)] == pid)
				return i;
		return -1;
	endfunction

	// expected result for one header; updates the mirror as the block should
	function automatic tsc_out_t predict_continuity(tsc_in_t hdr);
		tsc_out_t         res;
		int               idx;
		logic [CC_W-1:0]  exp_cc;
		logic [RUN_W-1:0] run;
		res = '0;
		idx = find_stream(hdr.stream_pid);
		if (idx < 0) begin
			// unknown PID: store it if there is room, otherwise flag and drop
			res.new_stream = 1'b1;
			if (streams_stored >= SLOTS) begin
				res.table_full = 1'b1;
			end else begin
				pid_tab[SLOT_W'(streams_stored)] = hdr.stream_pid;
				cc_tab[SLOT_W'(streams_stored)]  = hdr.counter_value;
				run_tab[SLOT_W'(streams_stored)] = '0;
				streams_stored++;
			end
			return res;
		end
		exp_cc = cc_tab[SLOT_W'(idx)] + CC_STEP;    // wraps mod 16 at 4 bits
		run    = run_tab[SLOT_W'(idx)];
		if (exp_cc != hdr.counter_value) begin
			res.cc_mismatch = 1'b1;
			// saturated run does not move, so it cannot newly hit the threshold
			if (run != RUN_MAX) begin
				run               = run + RUN_W'(1);
				res.threshold_hit = (run == threshold);
			end
		end else begin
			run = '0;
		end
		run_tab[SLOT_W'(idx)] = run;
		cc_tab[SLOT_W'(idx)]  = hdr.counter_value;
		res.expected_value    = exp_cc;
		res.error_run         = run;
		return res;
	endfunction

	function automatic string fmt_result(tsc_out_t r);
		return $sformatf("new=%0d full=%0d ccerr=%0d exp_cc=%0d run=%0d hit=%0d",
			r.new_stream, r.table_full, r.cc_mismatch, r.expected_value,
			r.error_run, r.threshold_hit);
	endfunction

	task automatic report_mismatch(string what, tsc_out_t exp_r, tsc_out_t act_r);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t ERROR %s\n  expected: %s\n  actual:   %s", $realtime, what,
				fmt_result(exp_r), fmt_result(act_r));
	endtask

	// ------------------------------------------------------------------
	// Result side: random backpressure at negedge, checking at posedge
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				beats_out++;
				if (expected_results.size() == 0) begin
					report_mismatch("result beat with nothing outstanding", '0, out_data);
				end else begin
					tsc_out_t exp_r;
					exp_r = expected_results.pop_front();
					if (out_data.new_stream     !== exp_r.new_stream     ||
					    out_data.table_full     !== exp_r.table_full     ||
					    out_data.cc_mismatch    !== exp_r.cc_mismatch    ||
					    out_data.expected_value !== exp_r.expected_value ||
					    out_data.error_run      !== exp_r.error_run      ||
					    out_data.threshold_hit  !== exp_r.threshold_hit)
						report_mismatch($sformatf("result beat %0d differs", beats_out),
							exp_r, out_data);
				end
			end
			// watchdog: any beat on either side counts as progress
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no beat for %0d cycles, %0d results outstanding",
					$realtime, idle_cycles, expected_results.size());
				$display("** ts_continuity_counter_checker_unit: FAILED **");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Sends one header beat. Called at a negedge, returns at the negedge after the
	// beat was taken; valid stays up so back-to-back beats follow without a gap.
	task automatic send_header(input logic [PID_W-1:0] pid, input logic [CC_W-1:0] cc);
		tsc_in_t  hdr;
		tsc_out_t res;
		hdr.stream_pid    = pid;
		hdr.counter_value = cc;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data  <= hdr;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		res = predict_continuity(hdr);
		expected_results.push_back(res);
		beats_in++;
		n_new    += int'(res.new_stream);
		n_full   += int'(res.table_full);
		n_cc_err += int'(res.cc_mismatch);
		n_hits   += int'(res.threshold_hit);
		@(negedge clk);
	endtask

	// sender holds off until every outstanding result has been taken
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	// threshold writes only with the block idle; every header yields a result,
	// so an empty expectation queue means nothing is in flight
	task automatic write_threshold(input logic [RUN_W-1:0] value);
		wait_results_drained();
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
		threshold  = value;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// threshold comes out of reset at 10: ten back-to-back errors raise the flag once
	task automatic test_default_threshold();
		send_header('0, 4'd5);
		repeat (11)
			send_header('0, 4'd5);    // repeats the last counter, always an error
		send_header('0, 4'd6);        // in sequence again: run clears
	endtask

	// top threshold: a short error run stays far below it, then clears
	task automatic test_high_threshold();
		write_threshold(RUN_MAX);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (5)
			send_header('0, 4'd6);
		send_header('0, 4'd7);
	endtask

	// a zero threshold can never match an incremented run
	task automatic test_threshold_zero();
		write_threshold('0);
		repeat (3)
			send_header('0, 4'd7);
		send_header('0, 4'd8);
	endtask

	// PID and counter extremes, counter wrap, threshold of one
	task automatic test_field_extremes();
		write_threshold(16'd1);
		send_header(13'h1FFF, 4'd15);
		send_header(13'h1FFF, 4'd0);     // 15 -> 0 wrap is in sequence
		send_header(13'h1FFF, 4'd0);     // first error: hits threshold 1
		send_header(13'h1FFF, 4'd0);     // run 2, past the threshold
		send_header(13'h1FFF, 4'd1);
		send_header(13'h0AAA, 4'd10);
		send_header(13'h1555, 4'd5);
		send_header(13'h0AAA, 4'd11);
		send_header(13'h1555, 4'd9);
		send_header('0, 4'd15);          // slot 0 error from counter 8
	endtask

	// Mostly well-formed streams with random content: known PIDs with the right
	// counter, injected counter errors, a sticky PID choice so error runs build up,
	// and now and then a fresh PID while the table may still grow to grow_cap.
	task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
	                                input logic [RUN_W-1:0] thr, input int unsigned beats,
	                                input int unsigned grow_cap);
		int               idx;
		logic [PID_W-1:0] pid;
		logic [CC_W-1:0]  cc;
		logic [CC_W-1:0]  skew;
		write_threshold(thr);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < int'(beats); n++) begin
			if (streams_stored == 0 ||
			    ($urandom_range(0, 99) < 6 && streams_stored < grow_cap)) begin
				pid      = PID_W'($urandom_range(0, (1 << PID_W) - 1));
				cc       = CC_W'($urandom_range(0, (1 << CC_W) - 1));
				last_idx = -1;
			end else begin
				if (last_idx >= 0 && last_idx < int'(streams_stored) && $urandom_range(0, 1))
					idx = last_idx;
				else
					idx = int'($urandom_range(0, streams_stored - 1));
				last_idx = idx;
				pid      = pid_tab[SLOT_W'(idx)];
				cc       = cc_tab[SLOT_W'(idx)] + CC_STEP;
				if ($urandom_range(0, 99) < 30) begin
					skew = CC_W'($urandom_range(1, (1 << CC_W) - 1));
					cc   = cc + skew;
				end
			end
			send_header(pid, cc);
		end
	endtask

	// fill every slot, then unknown PIDs must be flagged and dropped while the
	// last slot keeps working
	task automatic test_table_full();
		logic [PID_W-1:0] pid;
		logic [CC_W-1:0]  cc;
		write_threshold(16'd3);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (streams_stored < SLOTS) begin
			pid = PID_W'($urandom_range(0, (1 << PID_W) - 1));
			cc  = CC_W'($urandom_range(0, (1 << CC_W) - 1));
			if (find_stream(pid) < 0)
				send_header(pid, cc);
		end
		for (int n = 0; n < 4; n++) begin
			do
				pid = PID_W'($urandom_range(0, (1 << PID_W) - 1));
			while (find_stream(pid) >= 0);
			send_header(pid, CC_W'($urandom_range(0, (1 << CC_W) - 1)));
			send_header(pid, CC_W'($urandom_range(0, (1 << CC_W) - 1)));   // still unknown
		end
		pid = pid_tab[SLOT_W'(SLOTS-1)];
		send_header(pid, cc_tab[SLOT_W'(SLOTS-1)] + CC_STEP);
		repeat (3)
			send_header(pid, cc_tab[SLOT_W'(SLOTS-1)]);             // hits threshold 3
		send_header(pid, cc_tab[SLOT_W'(SLOTS-1)] + CC_STEP);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		out_ready      = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		streams_stored = 0;
		threshold      = THRESHOLD_RESET;
		mismatches     = 0;
		idle_cycles    = 0;
		beats_in       = 0;
		beats_out      = 0;
		n_new          = 0;
		n_full         = 0;
		n_cc_err       = 0;
		n_hits         = 0;
		last_idx       = -1;
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_default_threshold();
		test_high_threshold();
		test_threshold_zero();
		test_field_extremes();
		// idling phases: none, sender, receiver, both
		run_random_phase(0, 0, 16'd2, PHASE_BEATS, 24);
		run_random_phase(67, 0, 16'd3, PHASE_BEATS, 40);
		run_random_phase(0, 67, 16'd1, PHASE_BEATS, 56);
		run_random_phase(17, 17, 16'd4, PHASE_BEATS, 64);
		test_table_full();
		// full table: fresh PIDs now all bounce off as table_full
		run_random_phase(17, 17, 16'd2, 300, SLOTS + 1);

		wait_results_drained();
		repeat (TAIL_CYCLES)
			@(negedge clk);

		$display("Run: %0d header beats in, %0d result beats out; %0d new PIDs, %0d table-full",
			beats_in, beats_out, n_new, n_full);
		$display("     %0d counter errors, %0d threshold hits", n_cc_err, n_hits);
		if (mismatches == 0) begin
			$display("** ts_continuity_counter_checker_unit: PASSED **");
		end else begin
			$display("%0d mismatching results", mismatches);
			$display("** ts_continuity_counter_checker_unit: FAILED **");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/tsc_pkg.sv
src/tsc_front.sv
src/tsc_back.sv
src/ts_continuity_counter_checker_unit.sv
src/tsc_checker.sv
test/tb_ts_continuity_counter_checker_unit.sv
